/* hw/rtl/toroidal_life_grid_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// Life grid engine assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_LIFE_GRID_ENGINE_TOP_DEFINES_SVH
`define TOROIDAL_LIFE_GRID_ENGINE_TOP_DEFINES_SVH
// implication checked every clock outside reset
`define TLG_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication
`define TLG_ASSERT_NXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

/* hw/rtl/tlg_pkg.sv */
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types and constants of the life grid engine.
// ----------------------------------------------------------------------------
package tlg_pkg;
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int DIM_W = 9;
    localparam int GEN_W = 16;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic [MAX_COLS-1:0] row_t;

    // row memory port request
    typedef struct packed {
        logic             rd_en;
        logic             rd_bank;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic             wr_bank;
        logic [ROW_W-1:0] wr_addr;
        row_t             wr_data;
    } mem_req_t;

    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(3)) r = DIM_W'(3);
        else if (v > maxv) r = maxv;
        else r = v;
        return r;
    endfunction

    // next generation of one row from its three source rows
    function automatic row_t life_row(input row_t up, input row_t mid, input row_t dn,
                                      input logic [DIM_W-1:0] w);
        row_t res;
        logic [COL_W-1:0] cl, cr;
        logic [3:0] n;
        res = mid;
        for (int c = 0; c < MAX_COLS; c++) begin
            if (DIM_W'(c) < w) begin
                cl = (c == 0) ? COL_W'(w - DIM_W'(1)) : COL_W'(c - 1);
                cr = (DIM_W'(c + 1) == w) ? COL_W'(0) : COL_W'(c + 1);
                n = 4'(up[cl]) + 4'(up[c]) + 4'(up[cr]) + 4'(mid[cl]) + 4'(mid[cr])
                  + 4'(dn[cl]) + 4'(dn[c]) + 4'(dn[cr]);
                res[c] = (n == 4'd3) || (mid[c] && n == 4'd2);
            end
        end
        return res;
    endfunction
endpackage

/* hw/rtl/toroidal_life_grid_engine_top.sv */
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine_top
// Conway life engine on a wrapping grid of up to 256 x 256 cells.
// ----------------------------------------------------------------------------
// Use: one request on s_* (op, row, col, cell_in) gives one result on m_*
// (cell_out, generation). Op 0 writes a cell, 1 advances a generation,
// 2 reads a cell, 3 does nothing. Grid size is set through cfg_we/cfg_index/
// cfg_data while idle (a rule on the user, not enforced by the block); sizes clamp to 3..256.
// Sequence: a write or read accesses the row memory before its result, a
// no-op goes straight to the result; a generation sweeps all 256 rows, each
// row in use needs three row reads plus a write, each row past the height is
// read once and copied into the new bank.
// One request is in flight at a time; s_ready is low until the result is
// taken.
// Reset: the row memory is cleared by a pass over all 512 rows (both banks)
// with s_ready low; sizes return to 256, generation count to 0.
// Stall: a result holds on m_* until m_ready.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [tlg_pkg::DIM_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [tlg_pkg::ROW_W-1:0]   s_row,
    input  logic [tlg_pkg::COL_W-1:0]   s_col,
    input  logic                        s_cell_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_cell_out,
    output logic [tlg_pkg::GEN_W-1:0]   m_generation
);
    tlg_pkg::mem_req_t req;
    tlg_pkg::row_t     rd_data;

    tlg_ctrl u_ctrl (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_op, .s_row, .s_col, .s_cell_in,
        .m_valid, .m_ready, .m_cell_out, .m_generation,
        .req, .rd_data
    );

    tlg_row_mem u_mem (
        .aclk, .req, .rd_data
    );
endmodule

/* hw/rtl/tlg_row_mem.sv */
// ----------------------------------------------------------------------------
// tlg_row_mem
// Two banks of row-wide grid storage, one read and one write port.
// ----------------------------------------------------------------------------
module tlg_row_mem (
    input  logic              aclk,
    input  tlg_pkg::mem_req_t req,
    output tlg_pkg::row_t     rd_data
);
    tlg_pkg::row_t mem [2*tlg_pkg::MAX_ROWS];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[{req.wr_bank, req.wr_addr}] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[{req.rd_bank, req.rd_addr}];
        end
    end
endmodule

/* hw/rtl/tlg_ctrl.sv */
// ----------------------------------------------------------------------------
// tlg_ctrl
// Sequencer: clear pass, cell access and generation sweep over the rows.
// ----------------------------------------------------------------------------
module tlg_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [tlg_pkg::DIM_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [tlg_pkg::ROW_W-1:0]   s_row,
    input  logic [tlg_pkg::COL_W-1:0]   s_col,
    input  logic                        s_cell_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_cell_out,
    output logic [tlg_pkg::GEN_W-1:0]   m_generation,
    output tlg_pkg::mem_req_t           req,
    input  tlg_pkg::row_t               rd_data
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACC_RD, S_ACC_DO, S_G_RD, S_G_CAP, S_G_WR, S_RESP
    } state_t;

    localparam int DW = tlg_pkg::DIM_W;
    localparam int RW = tlg_pkg::ROW_W;

    state_t                 state_reg;
    logic [DW-1:0]          width_reg, height_reg;
    logic                   bank_reg;
    logic [tlg_pkg::GEN_W-1:0] gen_reg;
    logic [RW:0]            clr_reg;
    logic [1:0]             op_reg;
    logic [RW-1:0]          row_reg;
    logic [tlg_pkg::COL_W-1:0] col_reg;
    logic                   cin_reg, inside_reg;
    logic [DW-1:0]          r_reg;      // output row being built
    logic [1:0]             k_reg;      // which source row is being read
    tlg_pkg::row_t          up_reg, mid_reg, dn_reg;
    logic                   out_reg;

    logic [DW-1:0] w_eff, h_eff;
    logic [DW-1:0] src_row;
    tlg_pkg::row_t wrow;

    assign w_eff = tlg_pkg::eff_size(width_reg, DW'(tlg_pkg::MAX_COLS));
    assign h_eff = tlg_pkg::eff_size(height_reg, DW'(tlg_pkg::MAX_ROWS));
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_RESP);
    assign m_cell_out = out_reg;
    assign m_generation = gen_reg;

    always_comb begin
        case (k_reg)
            2'd0:    src_row = (r_reg == '0) ? h_eff - DW'(1) : r_reg - DW'(1);
            2'd1:    src_row = r_reg;
            default: src_row = (r_reg + DW'(1) == h_eff) ? '0 : r_reg + DW'(1);
        endcase
        wrow = rd_data;
        wrow[col_reg] = cin_reg;
    end

    always_comb begin
        req = '0;
        case (state_reg)
            S_CLEAR: begin
                req.wr_en   = 1'b1;
                req.wr_bank = clr_reg[RW];
                req.wr_addr = clr_reg[RW-1:0];
            end
            S_ACC_RD: begin
                req.rd_en   = 1'b1;
                req.rd_bank = bank_reg;
                req.rd_addr = row_reg;
            end
            S_ACC_DO: begin
                req.wr_en   = inside_reg && (op_reg == tlg_pkg::OP_WRITE);
                req.wr_bank = bank_reg;
                req.wr_addr = row_reg;
                req.wr_data = wrow;
            end
            S_G_RD: begin
                req.rd_en   = 1'b1;
                req.rd_bank = bank_reg;
                req.rd_addr = src_row[RW-1:0];
            end
            S_G_WR: begin
                req.wr_en   = 1'b1;
                req.wr_bank = ~bank_reg;
                req.wr_addr = r_reg[RW-1:0];
                // rows past the grid height are carried over unchanged
                req.wr_data = (r_reg >= h_eff) ? mid_reg
                            : tlg_pkg::life_row(up_reg, mid_reg, dn_reg, w_eff);
            end
            default: req = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            width_reg  <= DW'(256);
            height_reg <= DW'(256);
            bank_reg   <= 1'b0;
            gen_reg    <= '0;
            clr_reg    <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == tlg_pkg::CFG_WIDTH) width_reg <= cfg_data;
                else height_reg <= cfg_data;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + (RW+1)'(1);
                    if (clr_reg == {(RW+1){1'b1}}) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_op;
                        row_reg    <= s_row;
                        col_reg    <= s_col;
                        cin_reg    <= s_cell_in;
                        inside_reg <= ({1'b0, s_row} < h_eff) && ({1'b0, s_col} < w_eff);
                        out_reg    <= 1'b0;
                        r_reg      <= '0;
                        k_reg      <= 2'd0;
                        if (s_op == tlg_pkg::OP_STEP) state_reg <= S_G_RD;
                        else if (s_op == tlg_pkg::OP_NOP) state_reg <= S_RESP;
                        else state_reg <= S_ACC_RD;
                    end
                end
                S_ACC_RD: state_reg <= S_ACC_DO;
                S_ACC_DO: begin
                    if (op_reg == tlg_pkg::OP_READ) out_reg <= inside_reg && rd_data[col_reg];
                    state_reg <= S_RESP;
                end
                S_G_RD: state_reg <= S_G_CAP;
                S_G_CAP: begin
                    case (k_reg)
                        2'd0:    up_reg  <= rd_data;
                        2'd1:    mid_reg <= rd_data;
                        default: dn_reg  <= rd_data;
                    endcase
                    if (k_reg == 2'd2 || (k_reg == 2'd1 && r_reg >= h_eff)) begin
                        k_reg <= 2'd0;
                        state_reg <= S_G_WR;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= S_G_RD;
                    end
                end
                S_G_WR: begin
                    if (r_reg == DW'(tlg_pkg::MAX_ROWS - 1)) begin
                        bank_reg  <= ~bank_reg;
                        gen_reg   <= gen_reg + (tlg_pkg::GEN_W)'(1);
                        state_reg <= S_RESP;
                    end else begin
                        r_reg     <= r_reg + DW'(1);
                        k_reg     <= (r_reg + DW'(1) >= h_eff) ? 2'd1 : 2'd0;
                        state_reg <= S_G_RD;
                    end
                end
                S_RESP: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* hw/rtl/tlg_checker.sv */
// ----------------------------------------------------------------------------
// tlg_checker
// Port-level checks of the life grid engine.
// ----------------------------------------------------------------------------
`include "toroidal_life_grid_engine_top_defines.svh"
module tlg_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [1:0]                s_op,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_cell_out,
    input logic [tlg_pkg::GEN_W-1:0] m_generation
);
    `TLG_ASSERT_IMP(a_one_side, aclk, aresetn, m_valid, !s_ready)
    `TLG_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready,
                    m_valid && $stable(m_generation) && $stable(m_cell_out))
    `TLG_ASSERT_NXT(a_gen_step, aclk, aresetn,
                    s_valid && s_ready && s_op != tlg_pkg::OP_STEP,
                    $stable(m_generation))
endmodule

bind toroidal_life_grid_engine_top tlg_checker u_tlg_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_op,
    .m_valid, .m_ready, .m_cell_out, .m_generation
);

/* tb/tlg_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_result_checker
// Tracks the grid size and a shadow copy of the cell grid from the traffic it
// sees, predicts the result of every accepted request and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module tlg_result_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tlg_pkg::DIM_W-1:0] cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic [tlg_pkg::ROW_W-1:0] s_row,
    input  logic [tlg_pkg::COL_W-1:0] s_col,
    input  logic                      s_cell_in,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_cell_out,
    input  logic [tlg_pkg::GEN_W-1:0] m_generation,
    output int                        fail_count,
    output int                        pending
);
    import tlg_pkg::*;

    typedef struct {
        logic             alive;
        logic [GEN_W-1:0] gen;
    } life_result_t;

    life_result_t       expected_results[$];
    row_t               shadow_grid [MAX_ROWS];
    logic [GEN_W-1:0]   gen_count;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        int r;
        r = v;
        if (r < 3) r = 3;
        if (r > maxv) r = maxv;
        return r;
    endfunction

    task automatic advance_generation();
        row_t nxt [MAX_ROWS];
        int   w, h, ru, rd, cl, cr, n;
        w = clamp_dim(width_reg, MAX_COLS);
        h = clamp_dim(height_reg, MAX_ROWS);
        for (int r = 0; r < MAX_ROWS; r++) nxt[r] = shadow_grid[r];
        for (int r = 0; r < h; r++) begin
            ru = (r == 0) ? h - 1 : r - 1;
            rd = (r + 1 == h) ? 0 : r + 1;
            for (int c = 0; c < w; c++) begin
                cl = (c == 0) ? w - 1 : c - 1;
                cr = (c + 1 == w) ? 0 : c + 1;
                n = shadow_grid[ru][cl] + shadow_grid[ru][c] + shadow_grid[ru][cr]
                  + shadow_grid[r][cl] + shadow_grid[r][cr]
                  + shadow_grid[rd][cl] + shadow_grid[rd][c] + shadow_grid[rd][cr];
                nxt[r][c] = (n == 3) || (shadow_grid[r][c] && n == 2);
            end
        end
        for (int r = 0; r < MAX_ROWS; r++) shadow_grid[r] = nxt[r];
        gen_count = gen_count + GEN_W'(1);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        life_result_t exp_r;
        int           w, h;
        logic         in_grid;
        if (!aresetn) begin
            for (int r = 0; r < MAX_ROWS; r++) shadow_grid[r] = '0;
            gen_count  = '0;
            width_reg  = DIM_W'(256);
            height_reg = DIM_W'(256);
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_cell_out !== exp_r.alive)
                        report_mismatch("cell_out", m_cell_out, exp_r.alive);
                    if (m_generation !== exp_r.gen)
                        report_mismatch("generation", m_generation, exp_r.gen);
                end
            end
            if (s_valid && s_ready) begin
                w = clamp_dim(width_reg, MAX_COLS);
                h = clamp_dim(height_reg, MAX_ROWS);
                in_grid = (int'(s_row) < h) && (int'(s_col) < w);
                exp_r.alive = 1'b0;
                case (op_t'(s_op))
                    OP_WRITE: if (in_grid) shadow_grid[s_row][s_col] = s_cell_in;
                    OP_STEP:  advance_generation();
                    OP_READ:  if (in_grid) exp_r.alive = shadow_grid[s_row][s_col];
                    default: ;
                endcase
                exp_r.gen = gen_count;
                expected_results.push_back(exp_r);
            end
            if (cfg_we) begin
                if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
                else height_reg = cfg_data;
            end
        end
    end
endmodule

/* tb/toroidal_life_grid_engine_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine_top_tb
// Drives cell writes, generation steps, cell reads and no-ops into the life engine
// across a range of grid sizes, with random gaps and result stalls; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine_top_tb;
    import tlg_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_WIDTH;
    logic [DIM_W-1:0]   cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = OP_NOP;
    logic [ROW_W-1:0]   s_row = '0;
    logic [COL_W-1:0]   s_col = '0;
    logic               s_cell_in = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_cell_out;
    logic [GEN_W-1:0]   m_generation;
    int                 fail_count;
    int                 pending;
    bit                 calm = 1'b0;
    int                 grid_w = 256;
    int                 grid_h = 256;

    toroidal_life_grid_engine_top uut (.*);

    tlg_result_checker checker_i (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
    end

    task automatic send_request(input op_t op, input int row, input int col, input bit val);
        bit ready_seen;
        if (!calm) begin
            while ($urandom_range(0, 99) < 27) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_valid   = 1'b1;
        s_op      = op;
        s_row     = ROW_W'(row);
        s_col     = COL_W'(col);
        s_cell_in = val;
        do begin
            #1 ready_seen = s_ready;
            @(negedge aclk);
        end while (!ready_seen);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic set_size(input int w, input int h);
        wait_drained();
        repeat (8) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = CFG_WIDTH;
        cfg_data = DIM_W'(w);
        @(negedge aclk);
        cfg_index = CFG_HEIGHT;
        cfg_data = DIM_W'(h);
        @(negedge aclk);
        cfg_we = 1'b0;
        grid_w = (w < 3) ? 3 : (w > MAX_COLS) ? MAX_COLS : w;
        grid_h = (h < 3) ? 3 : (h > MAX_ROWS) ? MAX_ROWS : h;
    endtask

    task automatic random_phase(input int count, input bit hold_midway);
        int k, n, mode;
        k = 0;
        while (k < count) begin
            if (hold_midway && k >= count / 2 && k < count / 2 + 4) begin
                wait_drained();
                k = count / 2 + 4;
            end
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                n = $urandom_range(1, 8);
                repeat (n) send_request(OP_WRITE, $urandom_range(0, grid_h - 1),
                                        $urandom_range(0, grid_w - 1), $urandom_range(0, 3) != 0);
                n = $urandom_range(1, 3);
                repeat (n) send_request(OP_STEP, $urandom, $urandom, $urandom);
                n = $urandom_range(1, 4);
                repeat (n) send_request(OP_READ, $urandom_range(0, grid_h - 1),
                                        $urandom_range(0, grid_w - 1), $urandom);
                k += 10;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_request(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom);
                k += n;
            end
        end
    endtask

    initial begin
        int pw [8] = '{3, 4, 8, 16, 256, 5, 40, 3};
        int ph [8] = '{3, 5, 8, 12, 3, 20, 7, 256};
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // corners touch each other through the wrap
        send_request(OP_WRITE, 0, 0, 1'b1);
        send_request(OP_WRITE, 255, 255, 1'b1);
        send_request(OP_WRITE, 0, 255, 1'b1);
        send_request(OP_WRITE, 255, 0, 1'b1);
        send_request(OP_READ, 255, 255, 1'b0);
        send_request(OP_STEP, 0, 0, 1'b0);
        send_request(OP_READ, 0, 0, 1'b0);
        send_request(OP_READ, 0, 1, 1'b0);
        send_request(OP_NOP, 255, 255, 1'b1);
        send_request(OP_WRITE, 0, 0, 1'b0);
        send_request(OP_READ, 0, 0, 1'b0);
        send_request(OP_READ, 255, 0, 1'b0);

        set_size(0, 1);
        send_request(OP_WRITE, 5, 1, 1'b1);
        send_request(OP_WRITE, 1, 5, 1'b1);
        send_request(OP_READ, 5, 1, 1'b0);
        send_request(OP_WRITE, 1, 1, 1'b1);
        send_request(OP_WRITE, 2, 2, 1'b1);
        send_request(OP_STEP, 0, 0, 1'b0);
        send_request(OP_READ, 2, 2, 1'b0);
        send_request(OP_READ, 0, 0, 1'b0);

        set_size(511, 300);
        send_request(OP_READ, 255, 255, 1'b0);
        send_request(OP_STEP, 0, 0, 1'b0);
        send_request(OP_READ, 0, 255, 1'b0);

        for (int p = 0; p < 8; p++) begin
            set_size(pw[p], ph[p]);
            calm = (p == 3);
            random_phase((pw[p] * ph[p] > 1000) ? 120 : 230, p == 2);
        end
        calm = 1'b0;

        wait_drained();
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
